/* rtl/arsl_pkg.sv */
// shared types and constants of the address range symbol lookup
package arsl_pkg;

	localparam int KIND_W     = 4;
	localparam int ADDR_W     = 64;
	localparam int NAME_W     = 32;
	localparam int IDX_IN_W   = 14;
	localparam int COUNT_W    = 15;

	// stream payload layout
	localparam int S_TDATA_W  = 248;
	localparam int M_TDATA_W  = 96;
	localparam int IDX_LSB    = 0;
	localparam int KIND_LSB   = IDX_LSB + IDX_IN_W;
	localparam int START_LSB  = KIND_LSB + KIND_W;
	localparam int LENGTH_LSB = START_LSB + ADDR_W;
	localparam int NAME_LSB   = LENGTH_LSB + ADDR_W;
	localparam int QADDR_LSB  = NAME_LSB + NAME_W;

	// register port
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 64;
	localparam int REG_SEL_W  = 2;

	localparam logic [KIND_W-1:0] KIND_FUNCTION = 4'd2;

	localparam logic [REG_SEL_W-1:0] REG_COUNT    = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_BIAS     = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_STR_SIZE = 2'd2;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
		logic [NAME_W-1:0] name;
	} entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0]  bias;
		logic [NAME_W-1:0]  str_size;
	} cfg_t;

endpackage

/* rtl/arsl_alu.sv */
// shared 64-bit add/subtract unit with carry out
module arsl_alu (
	input  logic [arsl_pkg::ADDR_W-1:0] a,
	input  logic [arsl_pkg::ADDR_W-1:0] b,
	input  arsl_pkg::alu_op_t           op,
	output logic [arsl_pkg::ADDR_W-1:0] res,
	output logic                        carry
);

	logic [arsl_pkg::ADDR_W-1:0] b_op;
	logic [arsl_pkg::ADDR_W:0]   sum;

	// subtract as a + ~b + 1, carry set means no borrow
	assign b_op = (op == arsl_pkg::ALU_SUB) ? ~b : b;
	assign sum  = {1'b0, a} + {1'b0, b_op} +
		{{arsl_pkg::ADDR_W{1'b0}}, (op == arsl_pkg::ALU_SUB)};
	assign res   = sum[arsl_pkg::ADDR_W-1:0];
	assign carry = sum[arsl_pkg::ADDR_W];

endmodule

/* rtl/arsl_cfg.sv */
// configuration registers behind the apb port
module arsl_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arsl_pkg::PADDR_W-1:0] paddr,
	input  logic [arsl_pkg::PDATA_W-1:0] pwdata,
	output logic [arsl_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output arsl_pkg::cfg_t               cfg
);

	arsl_pkg::cfg_t                      cfg_q;
	logic [arsl_pkg::REG_SEL_W-1:0]      reg_sel;
	logic                                wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[arsl_pkg::PADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				arsl_pkg::REG_COUNT: begin
					cfg_q.count <= pwdata[arsl_pkg::COUNT_W-1:0];
				end
				arsl_pkg::REG_BIAS: begin
					cfg_q.bias <= pwdata;
				end
				arsl_pkg::REG_STR_SIZE: begin
					cfg_q.str_size <= pwdata[arsl_pkg::NAME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			arsl_pkg::REG_COUNT:    prdata = arsl_pkg::PDATA_W'(cfg_q.count);
			arsl_pkg::REG_BIAS:     prdata = cfg_q.bias;
			arsl_pkg::REG_STR_SIZE: prdata = arsl_pkg::PDATA_W'(cfg_q.str_size);
			default:                prdata = '0;
		endcase
	end

endmodule

/* rtl/address_range_symbol_lookup.sv */
// top level: symbol table, scan sequencer and result register
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tuser: func, tdata: load entry and query address
// m_*       out  m_tvalid / m_tready     tuser: found, tdata: name_offset, offset
// apb       in   psel & penable & pwrite symbol_count, bias, string_table_size
//
// a load is written to the table at the accepting edge
// a query subtracts the bias, then scans min(symbol_count, MAX_SYMBOLS) entries in table order;
// a match ends the scan early, every scanned entry
// spends one table read plus three passes through the shared adder
// (rel - start, start + length, diff - length)
// s_tready is low from a query's acceptance until its result sits in the output register
// reset clears control state only; the table holds no valid bits and needs no clearing
module address_range_symbol_lookup #(
	parameter int MAX_SYMBOLS = 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index, entry_kind, entry_start, entry_length, entry_name_offset,
	// address, zero pad
	input  logic [arsl_pkg::S_TDATA_W-1:0] s_tdata,
	// func
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// name_offset, offset
	output logic [arsl_pkg::M_TDATA_W-1:0] m_tdata,
	// found
	output logic                           m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [arsl_pkg::PADDR_W-1:0]   paddr,
	input  logic [arsl_pkg::PDATA_W-1:0]   pwdata,
	output logic [arsl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int AW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IX_W  = (AW > arsl_pkg::IDX_IN_W) ? AW : arsl_pkg::IDX_IN_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_BIAS = 7'b0000010,
		ST_READ = 7'b0000100,
		ST_SUB  = 7'b0001000,
		ST_WRAP = 7'b0010000,
		ST_CMP  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                        state_q, state_d;
	arsl_pkg::cfg_t                cfg;

	arsl_pkg::entry_t              sym_mem_q [MAX_SYMBOLS];
	arsl_pkg::entry_t              rd_q;
	arsl_pkg::entry_t              ld_entry;

	logic [arsl_pkg::IDX_IN_W-1:0] ld_idx;
	logic [IX_W-1:0]               ld_idx_ext;
	logic                          ld_we;
	logic                          in_acc;

	logic [arsl_pkg::ADDR_W-1:0]   addr_q, rel_q, diff_q;
	logic                          ge_q, wrap_q;
	logic [CNT_W-1:0]              idx_q, n_q, n_clamp, idx_nxt;
	logic                          last;

	logic                          res_found_q;
	logic [arsl_pkg::NAME_W-1:0]   res_name_q;
	logic [arsl_pkg::ADDR_W-1:0]   res_off_q;

	logic                          out_valid_q, out_found_q;
	logic [arsl_pkg::NAME_W-1:0]   out_name_q;
	logic [arsl_pkg::ADDR_W-1:0]   out_off_q;
	logic                          out_load;

	logic [arsl_pkg::ADDR_W-1:0]   alu_a, alu_b, alu_res;
	arsl_pkg::alu_op_t             alu_op;
	logic                          alu_carry;
	logic                          match;

	arsl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arsl_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.res   (alu_res),
		.carry (alu_carry)
	);

	// input unpacking
	assign ld_idx          = s_tdata[arsl_pkg::IDX_LSB +: arsl_pkg::IDX_IN_W];
	assign ld_entry.kind   = s_tdata[arsl_pkg::KIND_LSB +: arsl_pkg::KIND_W];
	assign ld_entry.start  = s_tdata[arsl_pkg::START_LSB +: arsl_pkg::ADDR_W];
	assign ld_entry.length = s_tdata[arsl_pkg::LENGTH_LSB +: arsl_pkg::ADDR_W];
	assign ld_entry.name   = s_tdata[arsl_pkg::NAME_LSB +: arsl_pkg::NAME_W];
	assign ld_idx_ext      = IX_W'(ld_idx);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	// loads beyond the table depth are dropped
	assign ld_we    = in_acc & (s_tuser == arsl_pkg::FUNC_LOAD) &
		(32'(ld_idx) < 32'(MAX_SYMBOLS));

	assign n_clamp = (32'(cfg.count) > 32'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS)
		: CNT_W'(cfg.count);
	assign idx_nxt = idx_q + CNT_W'(1);
	assign last    = (idx_nxt == n_q);

	// symbol table, one write port for loads and one registered read port for the scan
	always_ff @(posedge clk) begin
		if (ld_we) begin
			sym_mem_q[ld_idx_ext[AW-1:0]] <= ld_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= sym_mem_q[idx_q[AW-1:0]];
		end
	end

	// operand selection for the shared adder
	always_comb begin
		alu_a  = rel_q;
		alu_b  = rd_q.length;
		alu_op = arsl_pkg::ALU_SUB;
		unique case (state_q)
			ST_BIAS: begin
				alu_a  = addr_q;
				alu_b  = cfg.bias;
				alu_op = arsl_pkg::ALU_SUB;
			end
			ST_SUB: begin
				alu_a  = rel_q;
				alu_b  = rd_q.start;
				alu_op = arsl_pkg::ALU_SUB;
			end
			ST_WRAP: begin
				alu_a  = rd_q.start;
				alu_b  = rd_q.length;
				alu_op = arsl_pkg::ALU_ADD;
			end
			ST_CMP: begin
				alu_a  = diff_q;
				alu_b  = rd_q.length;
				alu_op = arsl_pkg::ALU_SUB;
			end
			default: begin
			end
		endcase
	end

	// in ST_CMP a clear carry means diff < length; an end that wraps never matches
	assign match = ~alu_carry & ge_q & ~wrap_q &
		(rd_q.kind == arsl_pkg::KIND_FUNCTION) &
		(rd_q.length != '0) &
		(rd_q.name < cfg.str_size);

	assign out_load = (state_q == ST_DONE) & (~out_valid_q | m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == arsl_pkg::FUNC_QUERY) begin
					state_d = ST_BIAS;
				end
			end
			ST_BIAS: begin
				state_d = (n_clamp == '0) ? ST_DONE : ST_READ;
			end
			ST_READ: state_d = ST_SUB;
			ST_SUB:  state_d = ST_WRAP;
			ST_WRAP: state_d = ST_CMP;
			ST_CMP: begin
				state_d = (match || last) ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_BIAS) begin
				idx_q <= '0;
			end else if (state_q == ST_CMP && !match && !last) begin
				idx_q <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= s_tdata[arsl_pkg::QADDR_LSB +: arsl_pkg::ADDR_W];
		end
		unique case (state_q)
			ST_BIAS: begin
				rel_q       <= alu_res;
				n_q         <= n_clamp;
				res_found_q <= 1'b0;
				res_name_q  <= '0;
				res_off_q   <= '0;
			end
			ST_SUB: begin
				diff_q <= alu_res;
				ge_q   <= alu_carry;
			end
			ST_WRAP: begin
				wrap_q <= alu_carry;
			end
			ST_CMP: begin
				if (match) begin
					res_found_q <= 1'b1;
					res_name_q  <= rd_q.name;
					res_off_q   <= diff_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_found_q <= res_found_q;
			out_name_q  <= res_name_q;
			out_off_q   <= res_off_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {out_off_q, out_name_q};

endmodule

/* rtl/arsl_chk.sv */
// port-level checks for the address range symbol lookup, bound to the top level
module arsl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [arsl_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// a load never blocks the next transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == arsl_pkg::FUNC_LOAD) |=> s_tready)
		else $error("input not ready after a load");

	// a query holds off further input while it scans
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == arsl_pkg::FUNC_QUERY) |=> !s_tready)
		else $error("input ready right after a query");

	// a miss carries an all-zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0))
		else $error("nonzero payload on a miss");

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind address_range_symbol_lookup arsl_chk u_arsl_chk (.*);

/* verif/address_range_symbol_lookup_test.sv */
// stream-level testbench of the address range symbol lookup against its own predictor
module address_range_symbol_lookup_test;

	import arsl_pkg::*;

	localparam int MAX_SYMBOLS = 16384;
	// entries 0 .. LOADED_SPAN-1 are written before any query scans them
	localparam int LOADED_SPAN = 8;

	localparam logic [PADDR_W-1:0] ADDR_COUNT    = {REG_COUNT, 3'b000};
	localparam logic [PADDR_W-1:0] ADDR_BIAS     = {REG_BIAS, 3'b000};
	localparam logic [PADDR_W-1:0] ADDR_STR_SIZE = {REG_STR_SIZE, 3'b000};
	localparam logic [PADDR_W-1:0] ADDR_SPARE    = 5'd24;

	typedef struct {
		func_t              func;
		logic [IDX_IN_W-1:0] index;
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  start;
		logic [ADDR_W-1:0]  length;
		logic [NAME_W-1:0]  name;
		logic [ADDR_W-1:0]  addr;
	} request_t;

	typedef struct {
		logic              found;
		logic [NAME_W-1:0] name;
		logic [ADDR_W-1:0] offset;
	} lookup_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// entry_index, entry_kind, entry_start, entry_length, entry_name_offset, address, pad
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// func
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// name_offset, offset
	logic [M_TDATA_W-1:0] m_tdata;
	// found
	logic                 m_tuser;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// predictor copy of the symbol table and registers
	logic [KIND_W-1:0]  sym_kind [MAX_SYMBOLS];
	logic [ADDR_W-1:0]  sym_start [MAX_SYMBOLS];
	logic [ADDR_W-1:0]  sym_len [MAX_SYMBOLS];
	logic [NAME_W-1:0]  sym_name [MAX_SYMBOLS];
	logic [COUNT_W-1:0] cur_count = '0;
	logic [ADDR_W-1:0]  cur_bias = '0;
	logic [NAME_W-1:0]  cur_str_size = '0;

	request_t request_queue[$];
	lookup_t  lookup_results[$];
	request_t in_flight;
	lookup_t  oldest;
	int       queued = 0;
	int       sent = 0;
	int       mismatches = 0;
	int       send_idle_pct = 30;
	int       recv_idle_pct = 86;

	address_range_symbol_lookup #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// first function entry that holds the relative address, in table order
	function automatic lookup_t resolve_symbol(input logic [ADDR_W-1:0] addr);
		lookup_t           r;
		logic [ADDR_W-1:0] rel;
		logic [ADDR_W-1:0] fin;
		int                n;
		r = '{found: 1'b0, name: '0, offset: '0};
		rel = addr - cur_bias;
		n = (cur_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(cur_count);
		for (int i = 0; i < n; i++) begin
			fin = sym_start[i] + sym_len[i];
			if (sym_kind[i] == KIND_FUNCTION && sym_len[i] != '0 && rel >= sym_start[i] &&
					rel < fin && sym_name[i] < cur_str_size) begin
				r.found = 1'b1;
				r.name = sym_name[i];
				r.offset = rel - sym_start[i];
				return r;
			end
		end
		return r;
	endfunction

	task automatic queue_load(input int index, input logic [KIND_W-1:0] kind,
			input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] length,
			input logic [NAME_W-1:0] name);
		request_t r;
		r.func = FUNC_LOAD;
		r.index = IDX_IN_W'(index);
		r.kind = kind;
		r.start = start;
		r.length = length;
		r.name = name;
		r.addr = rand64();
		request_queue.push_back(r);
		queued++;
	endtask

	task automatic queue_query(input logic [ADDR_W-1:0] addr);
		request_t r;
		r.func = FUNC_QUERY;
		r.index = IDX_IN_W'($urandom_range(MAX_SYMBOLS - 1));
		r.kind = KIND_W'($urandom_range(15));
		r.start = rand64();
		r.length = rand64();
		r.name = $urandom;
		r.addr = addr;
		request_queue.push_back(r);
		queued++;
	endtask

	task automatic queue_random_load();
		int                idx;
		logic [ADDR_W-1:0] length;
		logic [NAME_W-1:0] name;
		idx = ($urandom_range(9) < 7) ? $urandom_range(LOADED_SPAN - 1) :
			$urandom_range(MAX_SYMBOLS - 1);
		case ($urandom_range(9))
			0: length = '0;
			1: length = '1;
			2, 3: length = rand64();
			default: length = 64'($urandom_range(1, 4096));
		endcase
		name = (cur_str_size != '0 && $urandom_range(4) != 0) ? $urandom % cur_str_size :
			$urandom;
		queue_load(idx, ($urandom_range(3) != 0) ? KIND_FUNCTION : 4'($urandom_range(15)),
			rand64(), length, name);
	endtask

	task automatic wait_accepted();
		while (sent != queued) @(negedge clk);
	endtask

	// registers change only with the table quiet and no result outstanding
	task automatic wait_idle();
		while (sent != queued || lookup_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		case (addr)
			ADDR_COUNT: cur_count = value[COUNT_W-1:0];
			ADDR_BIAS: cur_bias = value;
			ADDR_STR_SIZE: cur_str_size = value[NAME_W-1:0];
			default: ;
		endcase
	endtask

	// fresh registers, three loads, then three queries mostly aimed inside loaded entries, then two more loads
	task automatic run_batch();
		int                k;
		logic [ADDR_W-1:0] a;
		wait_idle();
		write_reg(ADDR_COUNT, ($urandom_range(9) == 0) ? 64'd0 :
			64'($urandom_range(1, LOADED_SPAN)));
		write_reg(ADDR_BIAS, ($urandom_range(5) == 0) ? 64'd0 : rand64());
		write_reg(ADDR_STR_SIZE, ($urandom_range(7) == 0) ? 64'hFFFF_FFFF :
			64'($urandom_range(1, 32'hFFFF_FFFF)));
		repeat (3) queue_random_load();
		wait_accepted();
		repeat (3) begin
			if (cur_count != '0 && $urandom_range(4) != 0) begin
				k = $urandom_range(cur_count - 1);
				a = cur_bias + sym_start[k] +
					((sym_len[k] == '0) ? 64'd0 : rand64() % sym_len[k]);
			end else begin
				a = rand64();
			end
			queue_query(a);
		end
		repeat (2) queue_random_load();
	endtask

	// sender: one transaction in flight, gaps drawn per cycle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent++;
				if (in_flight.func == FUNC_QUERY) begin
					lookup_results.push_back(resolve_symbol(in_flight.addr));
				end else begin
					sym_kind[in_flight.index] = in_flight.kind;
					sym_start[in_flight.index] = in_flight.start;
					sym_len[in_flight.index] = in_flight.length;
					sym_name[in_flight.index] = in_flight.name;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_flight = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= in_flight.func;
					s_tdata <= {{(S_TDATA_W - QADDR_LSB - ADDR_W){1'b0}}, in_flight.addr,
						in_flight.name, in_flight.length, in_flight.start, in_flight.kind,
						in_flight.index};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lookup_results.size() == 0) begin
					$display("%0t: result with none expected: found %b name %h offset %h",
						$time, m_tuser, m_tdata[NAME_W-1:0], m_tdata[NAME_W +: ADDR_W]);
					mismatches++;
				end else begin
					oldest = lookup_results.pop_front();
					if (m_tuser !== oldest.found) begin
						$display("%0t: found expected %b actual %b", $time, oldest.found, m_tuser);
						mismatches++;
					end
					if (m_tdata[NAME_W-1:0] !== oldest.name) begin
						$display("%0t: name_offset expected %h actual %h", $time, oldest.name,
							m_tdata[NAME_W-1:0]);
						mismatches++;
					end
					if (m_tdata[NAME_W +: ADDR_W] !== oldest.offset) begin
						$display("%0t: offset expected %h actual %h", $time, oldest.offset,
							m_tdata[NAME_W +: ADDR_W]);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing scanned right after reset
		queue_query(64'h0);
		wait_idle();
		write_reg(ADDR_COUNT, 64'd8);
		write_reg(ADDR_BIAS, 64'h1000);
		write_reg(ADDR_STR_SIZE, 64'h10);
		write_reg(ADDR_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);

		queue_load(0, 4'd3, 64'h1000, 64'h100, 32'd5);
		queue_load(1, KIND_FUNCTION, 64'h1000, 64'h0, 32'd6);
		queue_load(2, KIND_FUNCTION, 64'h1000, 64'h100, 32'hFFFF_FFFF);
		queue_load(3, KIND_FUNCTION, 64'h1080, 64'h100, 32'd7);
		queue_load(4, KIND_FUNCTION, 64'h1000, 64'h200, 32'd8);
		// end wraps past the top of the address space
		queue_load(5, KIND_FUNCTION, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 32'd9);
		queue_load(6, 4'hF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		queue_load(7, KIND_FUNCTION, 64'hFFFF_FFFF_FFFF_F000, 64'hF00, 32'd0);
		queue_load(MAX_SYMBOLS - 1, KIND_FUNCTION, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 32'd1);

		queue_query(64'h2000);
		queue_query(64'h2090);
		// address below the bias wraps to the top
		queue_query(64'h0);
		queue_query(64'h0F80);
		queue_query(64'hFFFF_FFFF_FFFF_FFFF);
		queue_query(64'h1000);
		wait_idle();
		write_reg(ADDR_STR_SIZE, 64'hFFFF_FFFF);
		write_reg(ADDR_BIAS, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_query(64'h0FFF);
		wait_idle();
		write_reg(ADDR_STR_SIZE, 64'h0);
		queue_query(64'h2000);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 86 : 0;
			recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 30 : 0;
			repeat (4) run_batch();
		end

		wait_idle();
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("address_range_symbol_lookup test passed");
		else
			$display("address_range_symbol_lookup test failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("address_range_symbol_lookup test failed");
		$finish;
	end

endmodule
